FILE: sv/ntfm_pkg.sv
// shared types and constants for the nearest timestamp fix matcher
package ntfm_pkg;

  // history ring size
  localparam int unsigned HISTORY_DEPTH = 1024;
  localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

  // field widths
  localparam int unsigned TS_W    = 48;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned NSU_W   = 10;
  // microsecond time scaled to nanoseconds
  localparam int unsigned TNS_W   = TS_W + NSU_W;
  // query and difference, room for the added delay
  localparam int unsigned QUERY_W = TNS_W + 1;

  localparam logic [NSU_W-1:0] NS_PER_US = NSU_W'(1000);

  // operation codes
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  typedef struct packed {
    logic          operation;
    logic [47:0]   timestamp_us;
    logic [63:0]   lat_bits;
    logic [63:0]   lon_bits;
    logic [31:0]   alt_bits;
    logic [31:0]   eph_bits;
    logic [31:0]   epv_bits;
    logic          dr_flag;
  } in_t;

  typedef struct packed {
    logic          found;
    logic [47:0]   fix_timestamp_us;
    logic [63:0]   match_lat_bits;
    logic [63:0]   match_lon_bits;
    logic [31:0]   match_alt_bits;
    logic [31:0]   match_eph_bits;
    logic [31:0]   match_epv_bits;
    logic          match_dr_flag;
  } out_t;

  // one history entry as held in memory
  typedef struct packed {
    logic [47:0]   time_us;
    logic [63:0]   lat;
    logic [63:0]   lon;
    logic [31:0]   alt;
    logic [31:0]   eph;
    logic [31:0]   epv;
    logic          dr_flag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic store;   // write the accepted fix
    logic start;   // latch query, set up the walk
    logic walk;    // walk the history
    logic fetch;   // read the best entry
    logic load;    // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic walk_done;
    logic slot_free;
  } status_t;

endpackage

FILE: sv/ntfm_ram.sv
// generic single write port, single read port ram with registered read
module ntfm_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                             wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                             rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ntfm_ctrl.sv
// sequencing state machine for store and trigger transactions
module ntfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  ntfm_pkg::status_t status_i,
  output ntfm_pkg::cmd_t    cmd_o
);

  import ntfm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_STORE) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = status_i.empty ? S_LOAD : S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        if (status_i.slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/ntfm_dp.sv
// history memory, walk pipeline, best match tracking and output register
module ntfm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ntfm_pkg::cmd_t            cmd_i,
  output ntfm_pkg::status_t         status_o,
  input  ntfm_pkg::in_t             in_data_i,
  input  logic                      cfg_we_i,
  input  logic [31:0]               cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ntfm_pkg::out_t            out_data_o
);

  import ntfm_pkg::*;

  // control state
  logic [DELAY_W-1:0] delay_q;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_inc, wr_ptr_prev;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   iss_q;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_dec;
  logic               v1_q, v2_q, v3_q;
  logic               have_q;
  logic               out_valid_q;

  // payload state
  logic [QUERY_W-1:0] query_q;
  logic [TNS_W-1:0]   tns_q;
  logic [QUERY_W-1:0] diff_q, diff_d;
  logic [PTR_W-1:0]   a1_q, a2_q, a3_q;
  logic               last1_q, last2_q, last3_q;
  logic [QUERY_W-1:0] best_dist_q;
  logic [PTR_W-1:0]   best_addr_q;
  out_t               out_q, out_d;

  logic               walk_issue;
  logic               improve;
  logic               slot_free;
  logic [QUERY_W:0]   sub_qt;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             wr_entry, rd_entry;

  // ring pointer arithmetic
  assign wr_ptr_inc  = (wr_ptr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign wr_ptr_prev = (wr_ptr_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : wr_ptr_q - 1'b1;
  assign rd_ptr_dec  = (rd_ptr_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_q - 1'b1;

  assign walk_issue = cmd_i.walk && (iss_q < count_q);

  // history memory
  always_comb begin
    wr_entry.time_us = in_data_i.timestamp_us;
    wr_entry.lat     = in_data_i.lat_bits;
    wr_entry.lon     = in_data_i.lon_bits;
    wr_entry.alt     = in_data_i.alt_bits;
    wr_entry.eph     = in_data_i.eph_bits;
    wr_entry.epv     = in_data_i.epv_bits;
    wr_entry.dr_flag = in_data_i.dr_flag;
  end

  assign ram_re    = walk_issue || cmd_i.fetch;
  assign ram_raddr = cmd_i.fetch ? best_addr_q : rd_ptr_q;

  ntfm_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (HISTORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // absolute difference, borrow selects the direction
  always_comb begin
    sub_qt = {1'b0, query_q} - {1'b0, QUERY_W'(tns_q)};
    if (sub_qt[QUERY_W]) begin
      diff_d = QUERY_W'(tns_q) - query_q;
    end else begin
      diff_d = sub_qt[QUERY_W-1:0];
    end
  end

  assign improve = diff_q < best_dist_q;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.empty     = (count_q == '0);
    status_o.walk_done = cmd_i.walk && v3_q && (!improve || last3_q);
    status_o.slot_free = slot_free;
  end

  always_comb begin
    out_d = '0;
    if (have_q) begin
      out_d.found            = 1'b1;
      out_d.fix_timestamp_us = rd_entry.time_us;
      out_d.match_lat_bits   = rd_entry.lat;
      out_d.match_lon_bits   = rd_entry.lon;
      out_d.match_alt_bits   = rd_entry.alt;
      out_d.match_eph_bits   = rd_entry.eph;
      out_d.match_epv_bits   = rd_entry.epv;
      out_d.match_dr_flag    = rd_entry.dr_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      iss_q       <= '0;
      rd_ptr_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_data_i;
      end
      if (cmd_i.store) begin
        wr_ptr_q <= wr_ptr_inc;
        if (count_q != CNT_W'(HISTORY_DEPTH)) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.start) begin
        iss_q    <= '0;
        rd_ptr_q <= wr_ptr_prev;
        have_q   <= 1'b0;
      end else if (walk_issue) begin
        iss_q    <= iss_q + 1'b1;
        rd_ptr_q <= rd_ptr_dec;
      end
      if (cmd_i.walk && v3_q && improve) begin
        have_q <= 1'b1;
      end
      v1_q <= walk_issue;
      v2_q <= cmd_i.walk && v1_q;
      v3_q <= cmd_i.walk && v2_q;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q     <= QUERY_W'(QUERY_W'(in_data_i.timestamp_us) * QUERY_W'(NS_PER_US))
                     + QUERY_W'(delay_q);
      best_dist_q <= '1;
    end else if (cmd_i.walk && v3_q && improve) begin
      best_dist_q <= diff_q;
      best_addr_q <= a3_q;
    end
    // stage 1: address and last flag alongside the memory read
    a1_q    <= rd_ptr_q;
    last1_q <= (CNT_W'(iss_q + 1'b1) == count_q);
    // stage 2: scale stored time to nanoseconds
    tns_q   <= TNS_W'(TNS_W'(rd_entry.time_us) * TNS_W'(NS_PER_US));
    a2_q    <= a1_q;
    last2_q <= last1_q;
    // stage 3: distance to the query
    diff_q  <= diff_d;
    a3_q    <= a2_q;
    last3_q <= last2_q;
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/nearest_timestamp_fix_matcher_unit.sv
// top level of the nearest timestamp fix matcher
// Keeps a ring of up to HISTORY_DEPTH (1024) position fixes in one on-chip
// memory and answers camera trigger queries with the fix closest in time.
// A store transaction produces no result; once the ring
// is full the oldest fix is overwritten. A trigger transaction forms
// query = timestamp_us * 1000 + delay_ns and walks the ring newest first,
// one memory read per cycle through a three stage compare pipeline, and
// stops at the first entry that is not strictly closer than the best so
// far (so on a tie the newer fix wins). A trigger holds the input until its
// result is loaded into the output register; on an empty history it skips
// the walk and returns found=0 with all other fields zero. Results sit in
// an output register, so stores are taken while a result waits; a new
// trigger is taken too, but its own result waits until the previous one
// is taken. delay_ns is written through cfg_we_i / cfg_data_i and resets
// to zero; write it only while no trigger is in progress.
module nearest_timestamp_fix_matcher_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input transactions
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ntfm_pkg::in_t  in_data_i,
  // result transactions
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ntfm_pkg::out_t out_data_o,
  // delay register write
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i
);

  import ntfm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: idle, walk, fetch best entry, load output
  ntfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_data_i.operation),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: history ram, distance pipeline, best tracking, output register
  ntfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/ntfm_checker.sv
// port level checks for the nearest timestamp fix matcher, bound to the top level
module ntfm_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_o,
  input  ntfm_pkg::in_t  in_data_i,
  input  logic           out_valid_o,
  input  logic           out_ready_i,
  input  ntfm_pkg::out_t out_data_o
);

  import ntfm_pkg::*;

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // a miss carries all zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o == '0)
    else $error("miss result with nonzero fields");

  // a store transaction never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.operation == OP_STORE) && !out_valid_o
    |=> !out_valid_o)
    else $error("result raised by a store");

  // a trigger transaction blocks input while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.operation == OP_TRIGGER) |=> !in_ready_o)
    else $error("input taken during a trigger walk");

  // a new result appears only as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while still busy");

endmodule

bind nearest_timestamp_fix_matcher_unit ntfm_checker u_ntfm_checker (.*);
